@@ rtl/bvcp_pkg.sv @@
// bvcp_pkg: shared types, constants and curve tables for the battery charge unit
// used by bvcp_div and battery_voltage_to_charge_percent_unit; no dependencies
`default_nettype none

package bvcp_pkg;

  localparam int CURVE_POINTS = 13;
  localparam int REAL_POINTS  = CURVE_POINTS - 1;
  localparam int IDX_W        = $clog2(REAL_POINTS);

  localparam int MV_W     = 16;
  localparam int PCTX_W   = 14;
  localparam int PROD_W   = PCTX_W + MV_W;
  localparam int QUOT_W   = PCTX_W;
  localparam int NOMV_W   = 8;
  localparam int PCT_W    = 7;
  localparam int DIGIT8_W = 8;

  localparam logic [NOMV_W-1:0] NOM_24 = 8'd24;
  localparam logic [NOMV_W-1:0] NOM_36 = 8'd36;
  localparam logic [NOMV_W-1:0] NOM_48 = 8'd48;

  localparam logic [MV_W-1:0] INFER_48_MV = 16'd42000;
  localparam logic [MV_W-1:0] INFER_36_MV = 16'd30000;

  localparam logic [PCTX_W-1:0] ROUND_HALF = 14'd50;
  localparam logic [PCT_W-1:0]  PCT_FULL   = 7'd100;
  localparam logic [PCT_W-1:0]  PCT_EMPTY  = 7'd0;

  // floor(v / 100) == (v * 5243) >> 19 for every v below 2**14
  localparam int               RECIP_W     = 13;
  localparam logic [RECIP_W-1:0] RECIP_100 = 13'd5243;
  localparam int               RECIP_SHIFT = 19;
  localparam int               SCALED_W    = PCTX_W + RECIP_W;

  typedef enum logic [1:0] {
    CURVE_24,
    CURVE_36,
    CURVE_48
  } curve_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_SETUP,
    ST_MUL,
    ST_DIVGO,
    ST_DIVWAIT,
    ST_ROUND,
    ST_EMIT
  } state_t;

  localparam logic [PCTX_W-1:0] PCTX_TAB [REAL_POINTS] = '{
    14'd10000, 14'd9000, 14'd7500, 14'd6000, 14'd4500, 14'd3692,
    14'd3115,  14'd2000, 14'd1000, 14'd800,  14'd500,  14'd0
  };

  localparam logic [MV_W-1:0] MV_TAB_24 [REAL_POINTS] = '{
    16'd29000, 16'd27700, 16'd27000, 16'd26300, 16'd25600, 16'd25200,
    16'd25000, 16'd24500, 16'd24200, 16'd23800, 16'd23100, 16'd21000
  };

  localparam logic [MV_W-1:0] MV_TAB_36 [REAL_POINTS] = '{
    16'd40800, 16'd39500, 16'd38500, 16'd37500, 16'd36500, 16'd36000,
    16'd35600, 16'd35000, 16'd34500, 16'd34000, 16'd33000, 16'd31500
  };

  localparam logic [MV_W-1:0] MV_TAB_48 [REAL_POINTS] = '{
    16'd53800, 16'd51400, 16'd50100, 16'd48800, 16'd47500, 16'd46800,
    16'd46300, 16'd45500, 16'd44900, 16'd44200, 16'd42900, 16'd42000
  };

  function automatic logic [MV_W-1:0] curve_mv(input curve_t sel,
                                               input logic [IDX_W-1:0] idx);
    logic [MV_W-1:0] val;
    val = '0;
    if (int'(idx) < REAL_POINTS) begin
      unique case (sel)
        CURVE_24: val = MV_TAB_24[idx];
        CURVE_36: val = MV_TAB_36[idx];
        CURVE_48: val = MV_TAB_48[idx];
        default:  val = MV_TAB_24[idx];
      endcase
    end
    return val;
  endfunction

  function automatic logic [PCTX_W-1:0] curve_pctx(input logic [IDX_W-1:0] idx);
    logic [PCTX_W-1:0] val;
    val = '0;
    if (int'(idx) < REAL_POINTS) begin
      val = PCTX_TAB[idx];
    end
    return val;
  endfunction

endpackage

`default_nettype wire

@@ rtl/bvcp_div.sv @@
// bvcp_div: restoring divider, one quotient bit per cycle
// depends on bvcp_pkg for widths; quotient must fit in QUOT_W bits
`default_nettype none

module bvcp_div (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [bvcp_pkg::PROD_W-1:0] dividend,
  input  wire logic [bvcp_pkg::MV_W-1:0]   divisor,
  output logic                             done,
  output logic [bvcp_pkg::QUOT_W-1:0]      quotient
);

  localparam int MV_W   = bvcp_pkg::MV_W;
  localparam int QUOT_W = bvcp_pkg::QUOT_W;
  localparam int CNT_W  = $clog2(QUOT_W + 1);

  logic              busy;
  logic [CNT_W-1:0]  cnt;
  logic [MV_W-1:0]   rem;
  logic [MV_W-1:0]   rem_next;
  logic [MV_W:0]     shifted;
  logic [MV_W:0]     diff;
  logic              ge;

  // partial remainder stays below the divisor, so one extra bit suffices
  always_comb begin
    shifted  = {rem, quotient[QUOT_W-1]};
    diff     = shifted - {1'b0, divisor};
    ge       = (shifted >= {1'b0, divisor});
    rem_next = ge ? diff[MV_W-1:0] : shifted[MV_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(QUOT_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= dividend[bvcp_pkg::PROD_W-1:QUOT_W];
      quotient <= dividend[QUOT_W-1:0];
    end else if (busy) begin
      rem      <= rem_next;
      quotient <= {quotient[QUOT_W-2:0], ge};
    end
  end

endmodule

`default_nettype wire

@@ rtl/battery_voltage_to_charge_percent_unit.sv @@
// battery_voltage_to_charge_percent_unit: pack voltage to state of charge in percent
// depends on bvcp_pkg (curve tables, types) and bvcp_div (serial divider)
//
//  channel | handshake              | payload
//  --------+------------------------+----------------------------
//  input   | in_valid / in_stall    | battery_mv [15:0]
//  output  | out_valid / out_stall  | charge_percent [6:0]
//  config  | cfg_write              | nominal_volts [7:0]
//
// after accept, a beat steps through the sequencer until the result is registered:
// the curve search walks one point per cycle (up to 12 points), then setup, multiply
// and the 14-step restoring divider follow on interpolated voltages
// in_stall stays high from accept until the result is loaded into the output register
// the output register holds one result, so a new beat is taken while it waits
// rst is synchronous; it clears the sequencer, out_valid and the nominal register
`default_nettype none

module battery_voltage_to_charge_percent_unit (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_write,
  input  wire logic [bvcp_pkg::NOMV_W-1:0] nominal_volts,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [bvcp_pkg::MV_W-1:0]   battery_mv,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [bvcp_pkg::PCT_W-1:0]       charge_percent
);

  localparam int MV_W     = bvcp_pkg::MV_W;
  localparam int PCTX_W   = bvcp_pkg::PCTX_W;
  localparam int PROD_W   = bvcp_pkg::PROD_W;
  localparam int IDX_W    = bvcp_pkg::IDX_W;
  localparam int PCT_W    = bvcp_pkg::PCT_W;
  localparam int SCALED_W = bvcp_pkg::SCALED_W;
  localparam int D8_W     = bvcp_pkg::DIGIT8_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(bvcp_pkg::REAL_POINTS - 1);

  bvcp_pkg::state_t state;
  bvcp_pkg::state_t state_next;

  // configuration register
  logic [bvcp_pkg::NOMV_W-1:0] nominal;

  // working registers for the beat in flight
  logic [MV_W-1:0]     mv;
  bvcp_pkg::curve_t    sel;
  bvcp_pkg::curve_t    sel_next;
  logic [IDX_W-1:0]    k;
  logic [MV_W-1:0]     dx;
  logic [MV_W-1:0]     diff;
  logic [PCTX_W-1:0]   dy;
  logic [PCTX_W-1:0]   y1;
  logic [PROD_W-1:0]   prod;
  logic [PCTX_W-1:0]   ysum;
  logic [PCT_W-1:0]    pct;

  // control decode
  logic in_fire;
  logic out_free;
  logic div_start;
  logic div_done;
  logic [PCTX_W-1:0] quot;

  // curve lookups: current point for the search, and the segment ends
  logic [MV_W-1:0]   pt_k;
  logic [MV_W-1:0]   pt_prev;
  logic [PCTX_W-1:0] pctx_k;
  logic [PCTX_W-1:0] pctx_prev;
  logic [IDX_W-1:0]  k_prev;
  logic              pt_hit;
  logic              seg_bad;

  // rounding through a reciprocal multiply
  logic [SCALED_W-1:0] scaled;
  logic [D8_W-1:0]     pct_raw;
  logic [PCT_W-1:0]    pct_round;

  assign in_fire  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    k_prev    = k - 1'b1;
    pt_k      = bvcp_pkg::curve_mv(sel, k);
    pt_prev   = bvcp_pkg::curve_mv(sel, k_prev);
    pctx_k    = bvcp_pkg::curve_pctx(k);
    pctx_prev = bvcp_pkg::curve_pctx(k_prev);
    pt_hit    = (pt_k <= mv);
    seg_bad   = (pt_prev <= pt_k);
  end

  // curve choice: a register value of 24, 36 or 48 wins, otherwise infer from the voltage
  always_comb begin
    if (nominal == bvcp_pkg::NOM_24) begin
      sel_next = bvcp_pkg::CURVE_24;
    end else if (nominal == bvcp_pkg::NOM_36) begin
      sel_next = bvcp_pkg::CURVE_36;
    end else if (nominal == bvcp_pkg::NOM_48) begin
      sel_next = bvcp_pkg::CURVE_48;
    end else if (battery_mv >= bvcp_pkg::INFER_48_MV) begin
      sel_next = bvcp_pkg::CURVE_48;
    end else if (battery_mv >= bvcp_pkg::INFER_36_MV) begin
      sel_next = bvcp_pkg::CURVE_36;
    end else begin
      sel_next = bvcp_pkg::CURVE_24;
    end
  end

  always_comb begin
    scaled    = ysum * bvcp_pkg::RECIP_100;
    pct_raw   = scaled[bvcp_pkg::RECIP_SHIFT +: D8_W];
    pct_round = (pct_raw > D8_W'(bvcp_pkg::PCT_FULL)) ? bvcp_pkg::PCT_FULL
                                                      : pct_raw[PCT_W-1:0];
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      bvcp_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_next = (battery_mv == '0) ? bvcp_pkg::ST_EMIT : bvcp_pkg::ST_SEARCH;
        end
      end
      bvcp_pkg::ST_SEARCH: begin
        if (pt_hit) begin
          state_next = (k == '0) ? bvcp_pkg::ST_EMIT : bvcp_pkg::ST_SETUP;
        end else if (k == LAST_IDX) begin
          state_next = bvcp_pkg::ST_EMIT;
        end
      end
      bvcp_pkg::ST_SETUP: begin
        state_next = seg_bad ? bvcp_pkg::ST_EMIT : bvcp_pkg::ST_MUL;
      end
      bvcp_pkg::ST_MUL:     state_next = bvcp_pkg::ST_DIVGO;
      bvcp_pkg::ST_DIVGO:   state_next = bvcp_pkg::ST_DIVWAIT;
      bvcp_pkg::ST_DIVWAIT: begin
        if (div_done) begin
          state_next = bvcp_pkg::ST_ROUND;
        end
      end
      bvcp_pkg::ST_ROUND:   state_next = bvcp_pkg::ST_EMIT;
      bvcp_pkg::ST_EMIT: begin
        if (out_free) begin
          state_next = bvcp_pkg::ST_IDLE;
        end
      end
      default: state_next = bvcp_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall  = (state != bvcp_pkg::ST_IDLE);
    div_start = (state == bvcp_pkg::ST_DIVGO);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bvcp_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      nominal <= '0;
    end else if (cfg_write) begin
      nominal <= nominal_volts;
    end
  end

  // datapath registers, loaded per sequencer step
  always_ff @(posedge clk) begin
    unique case (state)
      bvcp_pkg::ST_IDLE: begin
        mv  <= battery_mv;
        sel <= sel_next;
        k   <= '0;
        pct <= bvcp_pkg::PCT_EMPTY;
      end
      bvcp_pkg::ST_SEARCH: begin
        if (pt_hit) begin
          // at or above the full point reads 100
          if (k == '0) begin
            pct <= bvcp_pkg::PCT_FULL;
          end
        end else if (k != LAST_IDX) begin
          k <= k + 1'b1;
        end
      end
      bvcp_pkg::ST_SETUP: begin
        dx   <= pt_prev - pt_k;
        diff <= mv - pt_k;
        dy   <= (pctx_prev >= pctx_k) ? (pctx_prev - pctx_k) : '0;
        y1   <= pctx_k;
      end
      bvcp_pkg::ST_MUL: begin
        prod <= dy * diff;
      end
      bvcp_pkg::ST_DIVWAIT: begin
        if (div_done) begin
          ysum <= y1 + quot + bvcp_pkg::ROUND_HALF;
        end
      end
      bvcp_pkg::ST_ROUND: begin
        pct <= pct_round;
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == bvcp_pkg::ST_EMIT && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == bvcp_pkg::ST_EMIT && out_free) begin
      charge_percent <= pct;
    end
  end

  // span is positive and diff < span, so the quotient stays below dy
  bvcp_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (prod),
    .divisor  (dx),
    .done     (div_done),
    .quotient (quot)
  );

endmodule

`default_nettype wire

@@ sim/battery_voltage_to_charge_percent_unit_tb.sv @@
// battery_voltage_to_charge_percent_unit_tb: self-checking bench for the pack voltage
// to state of charge unit; drives voltage beats and checks every percent against a
// local curve predictor; depends on bvcp_pkg and battery_voltage_to_charge_percent_unit
`timescale 1ns / 1ps

module battery_voltage_to_charge_percent_unit_tb;

  localparam int MV_W   = bvcp_pkg::MV_W;
  localparam int NOMV_W = bvcp_pkg::NOMV_W;
  localparam int PCT_W  = bvcp_pkg::PCT_W;

  // generous ceiling; a clean run needs far less than this
  localparam int CYCLE_LIMIT = 1_000_000;
  // settle time after the last result, above the worst accept-to-result latency
  localparam int TAIL_CYCLES = 48;

  // soc curve in hundredths of a percent, shared by all three packs
  localparam int SOC_X100 [12] = '{
    10000, 9000, 7500, 6000, 4500, 3692, 3115, 2000, 1000, 800, 500, 0
  };
  // descending voltage breakpoints in mV, full point first
  localparam int PACK24_MV [12] = '{
    29000, 27700, 27000, 26300, 25600, 25200, 25000, 24500, 24200, 23800, 23100, 21000
  };
  localparam int PACK36_MV [12] = '{
    40800, 39500, 38500, 37500, 36500, 36000, 35600, 35000, 34500, 34000, 33000, 31500
  };
  localparam int PACK48_MV [12] = '{
    53800, 51400, 50100, 48800, 47500, 46800, 46300, 45500, 44900, 44200, 42900, 42000
  };

  logic                clk;
  logic                rst;
  logic                cfg_write;
  logic [NOMV_W-1:0]   nominal_volts;
  logic                in_valid;
  logic                in_stall;
  logic [MV_W-1:0]     battery_mv;
  logic                out_valid;
  logic                out_stall;
  logic [PCT_W-1:0]    charge_percent;

  // bench copy of the nominal voltage register
  logic [NOMV_W-1:0]   cur_nominal;
  // percentages still owed by the block, oldest first
  logic [PCT_W-1:0]    pending_pct [$];
  int                  error_count;
  int                  cycle_count;
  // idle rates in percent for the sender and the receiver
  int                  tx_gap_pct;
  int                  rx_stall_pct;
  // when set, neither side idles for a while
  bit                  quiet;

  battery_voltage_to_charge_percent_unit dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .nominal_volts  (nominal_volts),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .battery_mv     (battery_mv),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .charge_percent (charge_percent)
  );

  // 10 ns clock
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // runaway guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // voltage breakpoint k of the chosen pack curve
  function automatic int curve_point(input bvcp_pkg::curve_t sel, input int k);
    int v;
    case (sel)
      bvcp_pkg::CURVE_36: v = PACK36_MV[k];
      bvcp_pkg::CURVE_48: v = PACK48_MV[k];
      default:            v = PACK24_MV[k];
    endcase
    return v;
  endfunction

  // expected state of charge for one voltage under the given nominal setting
  function automatic logic [PCT_W-1:0] predict_charge_pct(input logic [MV_W-1:0] mv,
                                                          input logic [NOMV_W-1:0] nom);
    bvcp_pkg::curve_t sel;
    int m, k, x0, x1, y0, y1, dx, dy, y, pct;
    m = int'(mv);
    if (m == 0) return bvcp_pkg::PCT_EMPTY;
    // fixed pack, or infer it from the voltage itself
    if (nom == bvcp_pkg::NOM_24) sel = bvcp_pkg::CURVE_24;
    else if (nom == bvcp_pkg::NOM_36) sel = bvcp_pkg::CURVE_36;
    else if (nom == bvcp_pkg::NOM_48) sel = bvcp_pkg::CURVE_48;
    else if (m >= 42000) sel = bvcp_pkg::CURVE_48;
    else if (m >= 30000) sel = bvcp_pkg::CURVE_36;
    else sel = bvcp_pkg::CURVE_24;
    // first breakpoint at or below the voltage
    k = 0;
    while (k < 12 && curve_point(sel, k) > m) k++;
    if (k >= 12) return bvcp_pkg::PCT_EMPTY;
    if (k == 0) return bvcp_pkg::PCT_FULL;
    x0 = curve_point(sel, k - 1);
    x1 = curve_point(sel, k);
    y0 = SOC_X100[k - 1];
    y1 = SOC_X100[k];
    // flat or rising segment guards, unreachable with these curves
    if (x0 <= x1) return bvcp_pkg::PCT_EMPTY;
    dx = x0 - x1;
    dy = (y0 >= y1) ? (y0 - y1) : 0;
    y = y1;
    if (dy != 0 && m > x1) y = y1 + (dy * (m - x1)) / dx;
    // round to whole percent and clamp
    pct = (y + 50) / 100;
    if (pct > 100) pct = 100;
    return pct[PCT_W-1:0];
  endfunction

  // voltage mix: mostly inside the active curve, some on breakpoints, some near zero, some anywhere
  function automatic logic [MV_W-1:0] random_battery_mv(input logic [NOMV_W-1:0] nom);
    bvcp_pkg::curve_t sel;
    int lo, hi, r, k;
    if (nom == bvcp_pkg::NOM_24) sel = bvcp_pkg::CURVE_24;
    else if (nom == bvcp_pkg::NOM_36) sel = bvcp_pkg::CURVE_36;
    else if (nom == bvcp_pkg::NOM_48) sel = bvcp_pkg::CURVE_48;
    else sel = bvcp_pkg::curve_t'($urandom_range(0, 2));
    hi = curve_point(sel, 0) + 300;
    lo = curve_point(sel, 11) - 300;
    r = $urandom_range(0, 19);
    if (r == 0) return MV_W'($urandom_range(0, 2));
    if (r < 4) return MV_W'($urandom);
    if (r < 7) begin
      k = $urandom_range(0, 11);
      return MV_W'(curve_point(sel, k) + $urandom_range(0, 2) - 1);
    end
    return MV_W'($urandom_range(lo, hi));
  endfunction

  // one voltage beat; valid is left high so back-to-back beats never glitch it
  task automatic send_voltage(input logic [MV_W-1:0] mv);
    @(negedge clk);
    while (!quiet && tx_gap_pct != 0 && $urandom_range(0, 99) < tx_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    battery_mv <= mv;
    do @(posedge clk); while (in_stall);
    pending_pct.push_back(predict_charge_pct(mv, cur_nominal));
  endtask

  // drop valid and wait until every owed result has come back
  task automatic wait_results_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_pct.size() != 0) @(posedge clk);
  endtask

  // register write, only with the block idle
  task automatic set_nominal_volts(input logic [NOMV_W-1:0] v);
    wait_results_drained();
    @(negedge clk);
    cfg_write     <= 1'b1;
    nominal_volts <= v;
    @(negedge clk);
    cfg_write     <= 1'b0;
    cur_nominal = v;
  endtask

  // reset value infers the pack: zero, extremes, exact breakpoints and the
  // inference thresholds with their neighbors, plus alternating bit patterns
  task automatic test_inferred_pack_edges();
    logic [MV_W-1:0] mv_list [$];
    mv_list = '{16'd0, 16'd65535, 16'd29000, 16'd28999, 16'd21000, 16'd20999,
                16'd29999, 16'd30000, 16'd41999, 16'd42000, 16'd53800, 16'd53799,
                16'd40800, 16'd31499, 16'h5555, 16'hAAAA};
    foreach (mv_list[i]) send_voltage(mv_list[i]);
  endtask

  // fixed packs: a voltage far off its curve lands at full or empty, and one inside it interpolates
  task automatic test_fixed_pack_override();
    set_nominal_volts(bvcp_pkg::NOM_24);
    send_voltage(16'd40000);
    send_voltage(16'd24100);
    set_nominal_volts(bvcp_pkg::NOM_36);
    send_voltage(16'd20000);
    send_voltage(16'd35800);
    set_nominal_volts(bvcp_pkg::NOM_48);
    send_voltage(16'd1);
    send_voltage(16'd47000);
  endtask

  // random voltages under one register setting
  task automatic test_random_traffic(input logic [NOMV_W-1:0] nom, input int beats);
    set_nominal_volts(nom);
    for (int i = 0; i < beats; i++) begin
      // occasional stretches with no idling on either side
      if ($urandom_range(0, 39) == 0) quiet = !quiet;
      send_voltage(random_battery_mv(cur_nominal));
    end
    quiet = 1'b0;
  endtask

  // receiver stall, redrawn every cycle
  always @(negedge clk) begin
    if (!quiet && rx_stall_pct != 0) out_stall <= ($urandom_range(0, 99) < rx_stall_pct);
    else out_stall <= 1'b0;
  end

  // result checker: each accepted beat against the oldest expectation
  always @(posedge clk) begin : check_results
    logic [PCT_W-1:0] want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_pct.size() == 0) begin
        $display("%0t: unexpected result, expected none, got charge_percent=%0d",
                 $time, charge_percent);
        error_count++;
      end else begin
        want = pending_pct.pop_front();
        if (charge_percent !== want) begin
          $display("%0t: charge_percent mismatch, expected %0d, got %0d",
                   $time, want, charge_percent);
          error_count++;
        end
      end
    end
  end

  initial begin : run
    logic [NOMV_W-1:0] odd_nominal;
    rst           = 1'b1;
    cfg_write     = 1'b0;
    nominal_volts = '0;
    in_valid      = 1'b0;
    battery_mv    = '0;
    out_stall     = 1'b0;
    cur_nominal   = '0;
    error_count   = 0;
    cycle_count   = 0;
    quiet         = 1'b0;
    // sender light, receiver heavy
    tx_gap_pct    = 23;
    rx_stall_pct  = 81;

    repeat (8) @(negedge clk);
    rst <= 1'b0;

    test_inferred_pack_edges();
    test_fixed_pack_override();
    test_random_traffic(8'd0, 250);
    test_random_traffic(bvcp_pkg::NOM_24, 200);

    // sender heavy, receiver light
    tx_gap_pct   = 81;
    rx_stall_pct = 23;
    test_random_traffic(bvcp_pkg::NOM_36, 200);
    test_random_traffic(bvcp_pkg::NOM_48, 200);

    // full throughput
    tx_gap_pct   = 0;
    rx_stall_pct = 0;
    test_random_traffic(8'd255, 200);
    do odd_nominal = NOMV_W'($urandom_range(1, 254));
    while (odd_nominal == bvcp_pkg::NOM_24 || odd_nominal == bvcp_pkg::NOM_36 ||
           odd_nominal == bvcp_pkg::NOM_48);
    test_random_traffic(odd_nominal, 150);
    test_random_traffic(8'd0, 200);

    wait_results_drained();
    // catch any stray result after the last one owed
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
